// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AM_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define AM_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define AM_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ufcc_pkg.sv =====
// Shared types and constants of the union-find component counter.
package ufcc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;
  localparam int RANK_W    = $clog2(NODE_W + 1);

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } ufcc_in_t;

  typedef struct packed {
    logic               merged;
    logic [COUNT_W-1:0] component_count;
    logic               bad_node;
  } ufcc_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND,
    ST_CMP_RD,
    ST_CMP,
    ST_RANK_RD,
    ST_RANK_A,
    ST_LINK,
    ST_DONE
  } ufcc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic find_step;
    logic cmp_step;
    logic rd_follow;
    logic rank_b;
    logic rank_a_load;
    logic link;
    logic emit;
  } ufcc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_bad;
    logic at_root;
    logic at_end;
    logic sel_b;
    logic same_root;
    logic clear_last;
    logic out_busy;
  } ufcc_stat_t;

endpackage

// ===== design/ufcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ufcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ufcc_ctrl.sv =====
// Sequencer for clear, find, compress, link and result hand-off.
module ufcc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cfg_fire,
  input  ufcc_pkg::ufcc_stat_t  stat,
  output ufcc_pkg::ufcc_cmd_t   cmd
);

  ufcc_pkg::ufcc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufcc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ufcc_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = ufcc_pkg::ST_IDLE;
      end
      ufcc_pkg::ST_IDLE: begin
        in_ready = !cfg_fire;
        if (in_valid && !cfg_fire) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_bad ? ufcc_pkg::ST_DONE : ufcc_pkg::ST_FIND_RD;
        end
      end
      ufcc_pkg::ST_FIND_RD: state_nxt = ufcc_pkg::ST_FIND;
      ufcc_pkg::ST_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.at_root) state_nxt = ufcc_pkg::ST_CMP_RD;
        else cmd.rd_follow = 1'b1;
      end
      ufcc_pkg::ST_CMP_RD: state_nxt = ufcc_pkg::ST_CMP;
      ufcc_pkg::ST_CMP: begin
        cmd.cmp_step = 1'b1;
        if (stat.at_end) begin
          state_nxt = stat.sel_b ? ufcc_pkg::ST_RANK_RD : ufcc_pkg::ST_FIND_RD;
        end else begin
          cmd.rd_follow = 1'b1;
        end
      end
      ufcc_pkg::ST_RANK_RD: begin
        state_nxt = stat.same_root ? ufcc_pkg::ST_DONE : ufcc_pkg::ST_RANK_A;
      end
      ufcc_pkg::ST_RANK_A: begin
        cmd.rank_a_load = 1'b1;
        cmd.rank_b      = 1'b1;
        state_nxt       = ufcc_pkg::ST_LINK;
      end
      ufcc_pkg::ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = ufcc_pkg::ST_DONE;
      end
      ufcc_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ufcc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ufcc_pkg::ST_CLEAR;
    endcase
    // a node_count write restarts the clearing pass
    if (cfg_fire) state_nxt = ufcc_pkg::ST_CLEAR;
  end

endmodule

// ===== design/ufcc_dp.sv =====
// Datapath: parent and rank memories, walk registers, count and result register.
module ufcc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ufcc_pkg::ufcc_in_t            in_data,
  input  logic                          cfg_fire,
  input  logic [ufcc_pkg::COUNT_W-1:0]  cfg_node_count,
  input  logic                          out_ready,
  output logic                          out_valid,
  output ufcc_pkg::ufcc_out_t           out_data,
  input  ufcc_pkg::ufcc_cmd_t           cmd,
  output ufcc_pkg::ufcc_stat_t          stat
);

  localparam logic [ufcc_pkg::COUNT_W-1:0] MaxCount = ufcc_pkg::COUNT_W'(ufcc_pkg::MAX_NODES);
  localparam logic [ufcc_pkg::NODE_W-1:0]  LastIdx  = ufcc_pkg::NODE_W'(ufcc_pkg::MAX_NODES - 1);

  logic [ufcc_pkg::COUNT_W-1:0] node_count_r, node_count_nxt;
  logic [ufcc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [ufcc_pkg::NODE_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ufcc_pkg::ufcc_out_t          out_data_r, out_data_nxt;
  logic [ufcc_pkg::NODE_W-1:0]  node_a_r, node_a_nxt;
  logic [ufcc_pkg::NODE_W-1:0]  node_b_r, node_b_nxt;
  logic [ufcc_pkg::NODE_W-1:0]  cur_r, cur_nxt;
  logic [ufcc_pkg::NODE_W-1:0]  root_a_r, root_a_nxt;
  logic [ufcc_pkg::NODE_W-1:0]  root_b_r, root_b_nxt;
  logic                         sel_b_r, sel_b_nxt;
  logic [ufcc_pkg::RANK_W-1:0]  rank_a_r, rank_a_nxt;
  logic                         merged_r, merged_nxt;
  logic                         bad_r, bad_nxt;

  logic                         p_we;
  logic [ufcc_pkg::NODE_W-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;
  logic                         r_we;
  logic [ufcc_pkg::NODE_W-1:0]  r_waddr, r_raddr;
  logic [ufcc_pkg::RANK_W-1:0]  r_wdata, r_rdata;

  logic [ufcc_pkg::NODE_W-1:0]  root_sel;
  logic [ufcc_pkg::COUNT_W-1:0] cfg_clamped;
  logic                         at_root, at_end;

  ufcc_ram #(
    .WIDTH(ufcc_pkg::NODE_W),
    .DEPTH(ufcc_pkg::MAX_NODES)
  ) u_parent (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  ufcc_ram #(
    .WIDTH(ufcc_pkg::RANK_W),
    .DEPTH(ufcc_pkg::MAX_NODES)
  ) u_rank (
    .clk  (clk),
    .we   (r_we),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .raddr(r_raddr),
    .rdata(r_rdata)
  );

  assign root_sel = sel_b_r ? root_b_r : root_a_r;
  assign at_root  = (p_rdata == cur_r);
  assign at_end   = (cur_r == root_sel);

  assign p_raddr = cmd.rd_follow ? p_rdata : cur_r;
  assign r_raddr = cmd.rank_b ? root_b_r : root_a_r;

  // zero reads as one, anything past the table size as the table size
  always_comb begin
    if (cfg_node_count == '0) cfg_clamped = ufcc_pkg::COUNT_W'(1);
    else if (cfg_node_count > MaxCount) cfg_clamped = MaxCount;
    else cfg_clamped = cfg_node_count;
  end

  always_comb begin
    stat.in_bad     = ({1'b0, in_data.node_a} >= node_count_r) ||
                      ({1'b0, in_data.node_b} >= node_count_r);
    stat.at_root    = at_root;
    stat.at_end     = at_end;
    stat.sel_b      = sel_b_r;
    stat.same_root  = (root_a_r == root_b_r);
    stat.clear_last = (clr_idx_r == LastIdx);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // memory writes
  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = root_sel;
    r_we    = 1'b0;
    r_waddr = root_a_r;
    r_wdata = rank_a_r + ufcc_pkg::RANK_W'(1);
    if (cmd.clear_step) begin
      p_we    = 1'b1;
      p_waddr = clr_idx_r;
      p_wdata = clr_idx_r;
      r_we    = 1'b1;
      r_waddr = clr_idx_r;
      r_wdata = '0;
    end else if (cmd.cmp_step) begin
      p_we = !at_end;
    end else if (cmd.link) begin
      p_we = 1'b1;
      if (rank_a_r < r_rdata) begin
        p_waddr = root_a_r;
        p_wdata = root_b_r;
      end else begin
        p_waddr = root_b_r;
        p_wdata = root_a_r;
        r_we    = (rank_a_r == r_rdata);
      end
    end
  end

  always_comb begin
    node_count_nxt = node_count_r;
    count_nxt      = count_r;
    clr_idx_nxt    = clr_idx_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    cur_nxt        = cur_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    sel_b_nxt      = sel_b_r;
    rank_a_nxt     = rank_a_r;
    merged_nxt     = merged_r;
    bad_nxt        = bad_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.merged          = merged_r;
      out_data_nxt.component_count = count_r;
      out_data_nxt.bad_node        = bad_r;
    end

    if (cmd.clear_step) clr_idx_nxt = clr_idx_r + ufcc_pkg::NODE_W'(1);

    if (cmd.load) begin
      node_a_nxt = in_data.node_a;
      node_b_nxt = in_data.node_b;
      cur_nxt    = in_data.node_a;
      sel_b_nxt  = 1'b0;
      merged_nxt = 1'b0;
      bad_nxt    = stat.in_bad;
    end

    if (cmd.find_step) begin
      if (at_root) begin
        if (sel_b_r) root_b_nxt = cur_r;
        else root_a_nxt = cur_r;
        cur_nxt = sel_b_r ? node_b_r : node_a_r;
      end else begin
        cur_nxt = p_rdata;
      end
    end

    if (cmd.cmp_step) begin
      if (at_end) begin
        if (!sel_b_r) begin
          sel_b_nxt = 1'b1;
          cur_nxt   = node_b_r;
        end
      end else begin
        cur_nxt = p_rdata;
      end
    end

    if (cmd.rank_a_load) rank_a_nxt = r_rdata;

    if (cmd.link) begin
      merged_nxt = 1'b1;
      if (count_r != '0) count_nxt = count_r - ufcc_pkg::COUNT_W'(1);
    end

    if (cfg_fire) begin
      node_count_nxt = cfg_clamped;
      count_nxt      = cfg_clamped;
      clr_idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= MaxCount;
      count_r      <= MaxCount;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      count_r      <= count_nxt;
      clr_idx_r    <= clr_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    node_a_r   <= node_a_nxt;
    node_b_r   <= node_b_nxt;
    cur_r      <= cur_nxt;
    root_a_r   <= root_a_nxt;
    root_b_r   <= root_b_nxt;
    sel_b_r    <= sel_b_nxt;
    rank_a_r   <= rank_a_nxt;
    merged_r   <= merged_nxt;
    bad_r      <= bad_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/union_find_component_counter.sv =====
// Union-find component counter. A bad edge goes from IDLE straight to DONE; any other
// edge runs a find and a compress walk per endpoint and a rank read, then goes to DONE
// if both ends share a root, or loads node_a's root rank and links first on a merge.
// The next edge transfers in on the cycle its predecessor's result can leave; edges are
// walked one at a time on the single parent RAM read port. A stalled result holds
// the next result in DONE. Reset and cfg writes rerun the clear; in_ready low, cfg ready.
module union_find_component_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  // edge input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ufcc_pkg::ufcc_in_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output ufcc_pkg::ufcc_out_t           out_data,
  // node_count write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ufcc_pkg::COUNT_W-1:0]  cfg_node_count
);

  ufcc_pkg::ufcc_cmd_t  cmd;
  ufcc_pkg::ufcc_stat_t stat;
  logic                 cfg_fire;

  // config transfers are always taken; a write clamps node_count,
  // reloads the component count and restarts the clearing pass
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  // controller: clear sweep, find/compress walks for both endpoints,
  // rank read and link, then hands the result to the output register
  ufcc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cfg_fire(cfg_fire),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: parent/rank RAMs, walk registers, count, result register
  // (the result register lets the next edge transfer in while one waits)
  ufcc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data       (in_data),
    .cfg_fire      (cfg_fire),
    .cfg_node_count(cfg_node_count),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

// ===== design/ufcc_checker.sv =====
// Port-level checker for the union-find component counter, with its bind.
`include "assert_macros.svh"

module ufcc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input ufcc_pkg::ufcc_out_t  out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  `AM_NEXT_ALWAYS(a_reset_clears, clk, !rst_n, !in_ready, "input ready right after reset")
  `AM_NEXT(a_cfg_clears, clk, rst_n, cfg_valid && cfg_ready, !in_ready, "input ready after cfg write")
  `AM_HOLDS(a_bad_no_merge, clk, rst_n, out_valid && out_data.bad_node, !out_data.merged, "bad edge merged")
  `AM_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind union_find_component_counter ufcc_checker u_ufcc_checker (.*);

// ===== tb/tb_union_find_component_counter.sv =====
// Self-checking testbench of the union-find component counter.
module tb_union_find_component_counter;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  ufcc_pkg::ufcc_in_t           in_data        = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  ufcc_pkg::ufcc_out_t          out_data;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [ufcc_pkg::COUNT_W-1:0] cfg_node_count = '0;

  always #4 clk = ~clk;

  union_find_component_counter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  // ---------------------------------------------------------------------------
  // Shadow forest: our own copy of the parent/rank tables, the node count
  // and the number of components still apart.
  // ---------------------------------------------------------------------------
  int unsigned forest_parent [ufcc_pkg::MAX_NODES];
  int unsigned forest_rank   [ufcc_pkg::MAX_NODES];
  int unsigned forest_nodes;
  int unsigned forest_left;

  ufcc_pkg::ufcc_out_t expected_results [$];   // one entry per accepted edge, oldest first
  int unsigned         mismatches = 0;
  bit                  no_idle    = 1'b0;      // set for stretches without any gaps

  // Back to identity forest; count restarts at the node count.
  function automatic void clear_forest();
    for (int i = 0; i < ufcc_pkg::MAX_NODES; i++) begin
      forest_parent[i] = i;
      forest_rank[i]   = 0;
    end
    forest_left = forest_nodes;
  endfunction

  // Root search, then every node on the walked path points at the root.
  function automatic int unsigned locate_root(int unsigned x);
    int unsigned root;
    int unsigned cur;
    int unsigned nxt;
    root = x;
    while (forest_parent[root] != root) root = forest_parent[root];
    cur = x;
    while (cur != root) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
    end
    return root;
  endfunction

  // Applies one edge to the shadow forest and returns what the DUT must report.
  function automatic ufcc_pkg::ufcc_out_t predict_edge(logic [ufcc_pkg::NODE_W-1:0] a,
                                                       logic [ufcc_pkg::NODE_W-1:0] b);
    ufcc_pkg::ufcc_out_t res;
    int unsigned         ra;
    int unsigned         rb;
    res = '0;
    // Bad endpoint: nothing moves, count reported unchanged.
    if (a >= forest_nodes || b >= forest_nodes) begin
      res.bad_node        = 1'b1;
      res.component_count = forest_left[ufcc_pkg::COUNT_W-1:0];
      return res;
    end
    ra = locate_root(a);
    rb = locate_root(b);
    if (ra != rb) begin
      // union by rank, ties go to the root of node_a
      if (forest_rank[ra] < forest_rank[rb]) begin
        forest_parent[ra] = rb;
      end else if (forest_rank[ra] > forest_rank[rb]) begin
        forest_parent[rb] = ra;
      end else begin
        forest_parent[rb] = ra;
        forest_rank[ra]++;
      end
      if (forest_left > 0) forest_left--;
      res.merged = 1'b1;
    end
    res.component_count = forest_left[ufcc_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Edge transfer. Valid is left high after acceptance; the next call either
  // keeps it high (no gap) or drops it in the same step, so valid never gets
  // two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_edge(input logic [ufcc_pkg::NODE_W-1:0] a,
                           input logic [ufcc_pkg::NODE_W-1:0] b);
    int unsigned         gap;
    ufcc_pkg::ufcc_out_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.node_a <= a;
    in_data.node_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    want             = predict_edge(a, b);
    expected_results = {expected_results, want};
  endtask

  // node_count write; only issued once every pending result has come back.
  task automatic write_node_count(input logic [ufcc_pkg::COUNT_W-1:0] raw);
    int unsigned v;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_node_count <= raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // zero reads as one node, anything past the table as the full table
    v = raw;
    if (v < 1) v = 1;
    if (v > ufcc_pkg::MAX_NODES) v = ufcc_pkg::MAX_NODES;
    forest_nodes = v;
    clear_forest();
  endtask

  // Random edge for the current node count; a few carry an endpoint past it.
  task automatic send_random_edge();
    logic [ufcc_pkg::NODE_W-1:0] a;
    logic [ufcc_pkg::NODE_W-1:0] b;
    int unsigned                 sel;
    a = ufcc_pkg::NODE_W'($urandom_range(0, forest_nodes - 1));
    b = ufcc_pkg::NODE_W'($urandom_range(0, forest_nodes - 1));
    if (forest_nodes < ufcc_pkg::MAX_NODES && $urandom_range(0, 9) == 0) begin
      sel = $urandom_range(0, 2);
      if (sel != 1)
        a = ufcc_pkg::NODE_W'($urandom_range(forest_nodes, ufcc_pkg::MAX_NODES - 1));
      if (sel != 0)
        b = ufcc_pkg::NODE_W'($urandom_range(forest_nodes, ufcc_pkg::MAX_NODES - 1));
    end else if ($urandom_range(0, 19) == 0) begin
      b = a;   // self loop
    end
    send_edge(a, b);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order checker.
  // ---------------------------------------------------------------------------
  initial begin : drive_out_ready
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(input string what, input ufcc_pkg::ufcc_out_t want,
                                 input ufcc_pkg::ufcc_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected merged=%0d count=%0d bad=%0d, got %0d %0d %0d",
               $realtime, what, want.merged, want.component_count, want.bad_node,
               got.merged, got.component_count, got.bad_node);
  endtask

  always @(posedge clk) begin : check_results
    ufcc_pkg::ufcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t result with nothing outstanding: merged=%0d count=%0d bad=%0d",
                   $realtime, out_data.merged, out_data.component_count, out_data.bad_node);
      end else begin
        want = expected_results.pop_front();
        if (out_data.merged !== want.merged) report_mismatch("merged", want, out_data);
        if (out_data.component_count !== want.component_count)
          report_mismatch("component_count", want, out_data);
        if (out_data.bad_node !== want.bad_node) report_mismatch("bad_node", want, out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset value: all 1024 nodes, extremes of both index fields.
  task automatic test_full_table();
    send_edge(10'd0, 10'd1023);       // merge, extremes
    send_edge(10'd1023, 10'd0);       // already joined
    send_edge(10'd1023, 10'd1023);    // self loop at top index
    send_edge(10'd0, 10'd0);          // self loop at zero
    send_edge(10'h2AA, 10'h155);      // alternating bit patterns
    send_edge(10'h155, 10'd0);        // joins two multi-node sets
  endtask

  // Endpoints past node_count, and writes of 0 and above the table size.
  task automatic test_node_count_limits();
    write_node_count(11'd8);
    send_edge(10'd8, 10'd0);          // first endpoint just past the end
    send_edge(10'd0, 10'd8);          // second endpoint just past the end
    send_edge(10'd1023, 10'd1023);
    send_edge(10'd7, 10'd7);
    send_edge(10'd7, 10'd0);
    write_node_count(11'd0);          // taken as one node
    send_edge(10'd0, 10'd0);
    send_edge(10'd1, 10'd0);
    send_edge(10'd0, 10'd1);
    write_node_count(11'd2047);       // clamped to the full table
    send_edge(10'd1023, 10'd512);
    write_node_count(11'd1025);
    write_node_count(11'd2);
    send_edge(10'd0, 10'd1);          // down to a single component
    send_edge(10'd1, 10'd0);
  endtask

  // Rank-3 tree, then finds from its leaves so compression walks long paths.
  task automatic test_deep_paths();
    write_node_count(11'd16);
    send_edge(10'd0, 10'd1);
    send_edge(10'd2, 10'd3);
    send_edge(10'd1, 10'd3);
    send_edge(10'd4, 10'd5);
    send_edge(10'd6, 10'd7);
    send_edge(10'd5, 10'd7);
    send_edge(10'd3, 10'd7);
    send_edge(10'd15, 10'd6);         // lower-rank root under the big tree
    send_edge(10'd7, 10'd1);
  endtask

  // Random edges over a sequence of node counts; small counts fill up and
  // build deep trees, large ones spread over every index bit.
  task automatic test_random_forests();
    logic [ufcc_pkg::COUNT_W-1:0] settings [9];
    settings = '{11'd1024, 11'd16, 11'd5, 11'd64, 11'd2047, 11'd200, 11'd0, 11'd3,
                 11'd1000};
    settings[8] = ufcc_pkg::COUNT_W'($urandom_range(0, 2047));
    for (int p = 0; p < 9; p++) begin
      write_node_count(settings[p]);
      no_idle = (p == 3);
      repeat (72) send_random_edge();
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    forest_nodes = ufcc_pkg::MAX_NODES;
    clear_forest();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_full_table();
    test_node_count_limits();
    test_deep_paths();
    test_random_forests();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);   // room for any stray result

    if (mismatches == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ufcc_pkg.sv
design/ufcc_ram.sv
design/ufcc_ctrl.sv
design/ufcc_dp.sv
design/union_find_component_counter.sv
design/ufcc_checker.sv
tb/tb_union_find_component_counter.sv
